[rtl/core/epdm_pkg.sv]
package epdm_pkg;

   typedef enum logic [1:0] {
      KIND_START    = 2'd0,
      KIND_OVERFLOW = 2'd1,
      KIND_CAPTURE  = 2'd2,
      KIND_WAIT     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_MULT  = 2'd1,
      ST_CHECK = 2'd2,
      ST_DIV   = 2'd3
   } state_type;

   localparam logic [1:0] CSR_TIMEOUT_LIMIT = 2'd0;
   localparam logic [1:0] CSR_SCALE_MUL     = 2'd1;
   localparam logic [1:0] CSR_SCALE_DIV     = 2'd2;

   localparam logic [15:0] TIMEOUT_LIMIT_RESET = 16'd25000;
   localparam logic [15:0] SCALE_MUL_RESET     = 16'd343;
   localparam logic [15:0] SCALE_DIV_RESET     = 16'd2450;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] capture_value;
   } req_type;

   typedef struct packed {
      logic [15:0] distance;
      logic        timed_out;
   } rsp_type;

endpackage

[rtl/core/echo_pulse_distance_meter.sv]
// Echo pulse distance meter. Transactions on the req_ channel carry timer events: start,
// timer overflow, edge capture and wait tick. Start, overflow, rising capture and wait-tick
// transactions are each done as they are taken; a wait tick that reaches csr timeout_limit
// returns a result (distance 0, timed_out 1) at once. The falling capture holds off the
// next transaction until its result is formed: the tick count is formed, then come the
// 24x16 multiply, the saturation check and the restoring divider, which yields one quotient
// bit per cycle through a single 17-bit subtractor. A quotient that does not fit 16 bits is
// caught at the check and gives 65535 without running the divider. The result waits in an
// output register; no new transaction is taken while it waits, except in the cycle in which
// the result itself is taken.
module echo_pulse_distance_meter
   import epdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   state_type   state_ff, state_in;

   logic [15:0] timeout_limit_ff, scale_mul_ff, scale_div_ff;

   logic        measuring_ff, measuring_in;
   logic        await_falling_ff, await_falling_in;
   logic [15:0] rising_ff, rising_in;
   logic [7:0]  ovf_ff, ovf_in;
   logic [15:0] wait_ff, wait_in;

   logic [23:0] ticks_ff, ticks_in;
   logic [39:0] product_ff, product_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] quot_ff, quot_in;
   logic [3:0]  cnt_ff, cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        slot_free;
   logic [15:0] wait_next;
   logic        timeout_hit;
   logic        final_capture;
   logic [16:0] shifted;
   logic [16:0] trial;
   logic        saturate;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign wait_next     = wait_ff + {15'd0, (wait_ff != 16'hFFFF)};
   assign timeout_hit   = wait_next >= timeout_limit_ff;
   assign final_capture = accept && measuring_ff && await_falling_ff
                          && (req_data.kind == KIND_CAPTURE);

   // shared divider step: shift in one dividend bit, trial subtract
   assign shifted  = {rem_ff, quot_ff[15]};
   assign trial    = shifted - {1'b0, scale_div_ff};
   assign saturate = product_ff[39:16] >= {8'd0, scale_div_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (final_capture) state_in = ST_MULT;
         ST_MULT:  state_in = ST_CHECK;
         ST_CHECK: if (saturate) state_in = ST_IDLE;
                   else state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == 4'd15) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      measuring_in     = measuring_ff;
      await_falling_in = await_falling_ff;
      rising_in        = rising_ff;
      ovf_in           = ovf_ff;
      wait_in          = wait_ff;
      ticks_in         = ticks_ff;
      product_in       = product_ff;
      rem_in           = rem_ff;
      quot_in          = quot_ff;
      cnt_in           = cnt_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_data_in      = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.kind == KIND_START) begin
                  measuring_in     = 1'b1;
                  await_falling_in = 1'b0;
                  rising_in        = 16'd0;
                  ovf_in           = 8'd0;
                  wait_in          = 16'd0;
               end else if (measuring_ff) begin
                  case (req_data.kind)
                     KIND_OVERFLOW: begin
                        if (ovf_ff != 8'hFF) ovf_in = ovf_ff + 8'd1;
                     end
                     KIND_CAPTURE: begin
                        if (!await_falling_ff) begin
                           rising_in        = req_data.capture_value;
                           ovf_in           = 8'd0;
                           await_falling_in = 1'b1;
                        end else begin
                           measuring_in     = 1'b0;
                           await_falling_in = 1'b0;
                           // no overflow: width wraps at 16 bits
                           if (ovf_ff == 8'd0) begin
                              ticks_in = {8'd0, req_data.capture_value - rising_ff};
                           end else begin
                              ticks_in = {ovf_ff, req_data.capture_value}
                                         - {8'd0, rising_ff};
                           end
                        end
                     end
                     default: begin
                        wait_in = wait_next;
                        if (timeout_hit) begin
                           measuring_in          = 1'b0;
                           await_falling_in      = 1'b0;
                           rsp_valid_in          = 1'b1;
                           rsp_data_in.distance  = 16'd0;
                           rsp_data_in.timed_out = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         ST_MULT: begin
            product_in = ticks_ff * scale_mul_ff;
         end
         ST_CHECK: begin
            rem_in  = product_ff[31:16];
            quot_in = product_ff[15:0];
            cnt_in  = 4'd0;
            if (saturate) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.distance  = 16'hFFFF;
               rsp_data_in.timed_out = 1'b0;
            end
         end
         ST_DIV: begin
            if (!trial[16]) rem_in = trial[15:0];
            else rem_in = shifted[15:0];
            quot_in = {quot_ff[14:0], !trial[16]};
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.distance  = {quot_ff[14:0], !trial[16]};
               rsp_data_in.timed_out = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // the result slot is free at every entry to ST_IDLE from the divider path,
   // since no transaction is taken while the divider runs and the slot was free at accept
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         timeout_limit_ff <= TIMEOUT_LIMIT_RESET;
         scale_mul_ff     <= SCALE_MUL_RESET;
         scale_div_ff     <= SCALE_DIV_RESET;
         measuring_ff     <= 1'b0;
         await_falling_ff <= 1'b0;
         rising_ff        <= 16'd0;
         ovf_ff           <= 8'd0;
         wait_ff          <= 16'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         measuring_ff     <= measuring_in;
         await_falling_ff <= await_falling_in;
         rising_ff        <= rising_in;
         ovf_ff           <= ovf_in;
         wait_ff          <= wait_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TIMEOUT_LIMIT: timeout_limit_ff <= csr_wdata;
               CSR_SCALE_MUL:     scale_mul_ff     <= csr_wdata;
               CSR_SCALE_DIV:     scale_div_ff     <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ticks_ff    <= ticks_in;
      product_ff  <= product_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[tb/sv/echo_distance_checker.sv]
module echo_distance_checker
   import epdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          error_count,
   output int          open_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] limit_q;
   logic [15:0] mul_q;
   logic [15:0] div_q;

   logic        armed;
   logic        rise_seen;
   logic [15:0] rise_stamp;
   logic [7:0]  ovf_count;
   logic [15:0] tick_count;

   rsp_type     pending_readings[$];

   function automatic logic [15:0] predict_distance(input logic [15:0] falling);
      logic [23:0] ticks;
      logic [39:0] product;
      logic [39:0] quotient;
      // with no overflow a falling stamp below the rising one wraps at 16 bits
      if (ovf_count == 8'd0) begin
         ticks = {8'd0, falling - rise_stamp};
      end else begin
         ticks = {ovf_count, 16'd0} + {8'd0, falling} - {8'd0, rise_stamp};
      end
      if (div_q == 16'd0) begin
         return 16'hFFFF;
      end
      product = ticks * mul_q;
      quotient = product / div_q;
      if (quotient > 40'hFFFF) begin
         return 16'hFFFF;
      end
      return quotient[15:0];
   endfunction

   task automatic take_event(input req_type item);
      rsp_type reading;
      case (item.kind)
         KIND_START: begin
            armed = 1'b1;
            rise_seen = 1'b0;
            rise_stamp = 16'd0;
            ovf_count = 8'd0;
            tick_count = 16'd0;
         end
         KIND_OVERFLOW: begin
            if (armed && ovf_count != 8'hFF) begin
               ovf_count = ovf_count + 8'd1;
            end
         end
         KIND_CAPTURE: begin
            if (armed) begin
               if (!rise_seen) begin
                  rise_stamp = item.capture_value;
                  ovf_count = 8'd0;
                  rise_seen = 1'b1;
               end else begin
                  reading.distance = predict_distance(item.capture_value);
                  reading.timed_out = 1'b0;
                  pending_readings.push_back(reading);
                  armed = 1'b0;
                  rise_seen = 1'b0;
               end
            end
         end
         KIND_WAIT: begin
            if (armed) begin
               if (tick_count != 16'hFFFF) begin
                  tick_count = tick_count + 16'd1;
               end
               if (tick_count >= limit_q) begin
                  reading.distance = 16'd0;
                  reading.timed_out = 1'b1;
                  pending_readings.push_back(reading);
                  armed = 1'b0;
                  rise_seen = 1'b0;
               end
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type expected;
      if (reset) begin
         limit_q = TIMEOUT_LIMIT_RESET;
         mul_q = SCALE_MUL_RESET;
         div_q = SCALE_DIV_RESET;
         armed = 1'b0;
         rise_seen = 1'b0;
         rise_stamp = 16'd0;
         ovf_count = 8'd0;
         tick_count = 16'd0;
         pending_readings.delete();
         error_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TIMEOUT_LIMIT: limit_q = csr_wdata;
               CSR_SCALE_MUL:     mul_q = csr_wdata;
               CSR_SCALE_DIV:     div_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            take_event(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0) begin
               $display("%0t: unexpected reading, got distance %0d timed_out %0d",
                        $time, rsp_data.distance, rsp_data.timed_out);
               error_count++;
            end else begin
               expected = pending_readings.pop_front();
               if (rsp_data.distance !== expected.distance ||
                   rsp_data.timed_out !== expected.timed_out) begin
                  $display("%0t: expected %0d/%0d got %0d/%0d (distance/timed_out)",
                           $time, expected.distance, expected.timed_out,
                           rsp_data.distance, rsp_data.timed_out);
                  error_count++;
               end
            end
         end
      end
      open_count = pending_readings.size();
   end

endmodule

[tb/sv/echo_pulse_distance_meter_test.sv]
module echo_pulse_distance_meter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import epdm_pkg::*;

   localparam int QUIET_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SUB_ITEMS      = 43;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   int          error_count;
   int          open_count;
   int          items_sent;
   int          send_idle_pct;
   int          recv_idle_pct;
   logic        hold_request;
   int          hold_left;
   int          idle_cycles;

   echo_pulse_distance_meter u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   echo_distance_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .open_count  (open_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver: random back-pressure plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("echo_pulse_distance_meter test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   task automatic send_item(input kind_type kind, input logic [15:0] capture);
      req_type item;
      item.kind = kind;
      item.capture_value = capture;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      items_sent++;
   endtask

   // sender pause: every pending reading delivered, then the block settles
   task automatic wait_readings_done();
      @(negedge clock);
      req_valid <= 1'b0;
      while (open_count != 0) begin
         @(negedge clock);
      end
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_settings(input logic [15:0] limit, input logic [15:0] mul,
                                 input logic [15:0] div);
      csr_write(CSR_TIMEOUT_LIMIT, limit);
      csr_write(CSR_SCALE_MUL, mul);
      csr_write(CSR_SCALE_DIV, div);
   endtask

   task automatic send_filler_events(input int count);
      repeat (count) begin
         if ($urandom_range(1)) begin
            send_item(KIND_OVERFLOW, 16'($urandom));
         end else begin
            send_item(KIND_WAIT, 16'($urandom));
         end
      end
   endtask

   task automatic send_echo_traffic(input int budget);
      int stop_at;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 75) begin
            send_item(KIND_START, 16'($urandom));
            send_filler_events($urandom_range(0, 3));
            send_item(KIND_CAPTURE, 16'($urandom));
            send_filler_events($urandom_range(99) < 50 ? 0 : $urandom_range(1, 5));
            // some measurements are left unfinished on purpose
            if ($urandom_range(7) != 0) begin
               send_item(KIND_CAPTURE, 16'($urandom));
            end
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_item(kind_type'($urandom_range(3)), 16'($urandom));
            end
         end
      end
   endtask

   initial begin
      logic [15:0] limit;
      logic [15:0] mul;
      logic [15:0] div;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_TIMEOUT_LIMIT;
      csr_wdata = 16'd0;
      hold_request = 1'b0;
      items_sent = 0;
      idle_cycles = 0;
      send_idle_pct = 19;
      recv_idle_pct = 54;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // idle block ignores everything but start
      send_item(KIND_WAIT, 16'h0000);
      send_item(KIND_CAPTURE, 16'hFFFF);
      send_item(KIND_OVERFLOW, 16'h0000);
      send_item(KIND_START, 16'h0000);
      send_item(KIND_CAPTURE, 16'h0000);
      send_item(KIND_CAPTURE, 16'hFFFF);
      // overflow before the rising edge is dropped by the rising capture
      send_item(KIND_START, 16'h0000);
      send_item(KIND_OVERFLOW, 16'h0000);
      send_item(KIND_CAPTURE, 16'd100);
      send_item(KIND_OVERFLOW, 16'h0000);
      send_item(KIND_OVERFLOW, 16'h0000);
      send_item(KIND_CAPTURE, 16'd50);
      // falling below rising with no overflow wraps
      send_item(KIND_START, 16'h0000);
      send_item(KIND_CAPTURE, 16'hFFFF);
      send_item(KIND_CAPTURE, 16'h0000);
      // restart while measuring
      send_item(KIND_START, 16'h0000);
      send_item(KIND_CAPTURE, 16'd10);
      send_item(KIND_START, 16'h0000);
      send_item(KIND_CAPTURE, 16'd20);
      send_item(KIND_CAPTURE, 16'd30);
      wait_readings_done();

      write_settings(16'd0, 16'hFFFF, 16'd1);
      send_item(KIND_START, 16'h0000);
      send_item(KIND_CAPTURE, 16'h0000);
      send_item(KIND_CAPTURE, 16'hFFFF);
      // zero limit: first wait tick times out
      send_item(KIND_START, 16'h0000);
      send_item(KIND_WAIT, 16'h0000);
      wait_readings_done();

      // zero divisor
      write_settings(16'd3, 16'd343, 16'd0);
      send_item(KIND_START, 16'h0000);
      send_item(KIND_CAPTURE, 16'd1234);
      send_item(KIND_CAPTURE, 16'd1300);
      send_item(KIND_START, 16'h0000);
      send_item(KIND_WAIT, 16'h0000);
      send_item(KIND_CAPTURE, 16'd5);
      send_item(KIND_WAIT, 16'h0000);
      send_item(KIND_WAIT, 16'h0000);
      wait_readings_done();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: set_idling(19, 54);
            1: set_idling(54, 19);
            default: set_idling(0, 0);
         endcase
         for (int sub = 0; sub < 4; sub++) begin
            wait_readings_done();
            if (sub == 1) begin
               limit = 16'd1;
               mul = 16'd1;
               div = 16'hFFFF;
            end else if (sub == 2) begin
               limit = 16'hFFFF;
               mul = 16'hFFFF;
               div = 16'd1;
            end else begin
               limit = 16'($urandom_range(0, 24));
               mul = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1, 400));
               div = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
            end
            write_settings(limit, mul, div);
            if (phase == 0 && sub == 0) begin
               @(posedge clock);
               hold_request = 1'b1;
            end
            send_echo_traffic(SUB_ITEMS);
            // overflow count saturation on a long pulse
            if (phase == 2 && sub == 1) begin
               send_item(KIND_START, 16'h0000);
               send_item(KIND_CAPTURE, 16'($urandom));
               repeat (260) send_item(KIND_OVERFLOW, 16'($urandom));
               send_item(KIND_CAPTURE, 16'($urandom));
            end
         end
      end

      wait_readings_done();
      if (error_count == 0 && open_count == 0) begin
         $display("echo_pulse_distance_meter test passed");
      end else begin
         $display("echo_pulse_distance_meter test failed");
      end
      $finish;
   end

endmodule
